>>> src/assert_macros.svh
// Assertion macros used by the checker module.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define CHK_IMPL(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("check failed");

// Next-cycle implication outside reset.
`define CHK_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("check failed");

`endif

>>> src/lphm_pkg.sv
// Types and constants for the linear probe hash map.
// No dependencies.
package lphm_pkg;
  localparam logic [1:0] KIND_LOOKUP = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;
  localparam logic [31:0] HASH_MUL = 32'd2654435761;
endpackage

>>> src/lphm_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module lphm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> src/lphm_hash.sv
// Registered home-slot hash: key times the golden multiplier, modulo slots.
// Depends on lphm_pkg.
module lphm_hash import lphm_pkg::*; #(
  parameter int SLOTS = 256
) (
  input  logic                     clk,
  input  logic [31:0]              key,
  output logic [$clog2(SLOTS)-1:0] home
);
  localparam int AW = $clog2(SLOTS);
  logic [31:0] prod;
  logic [31:0] rem;

  always_comb begin
    rem = prod % 32'(SLOTS);
  end

  always_ff @(posedge clk) begin
    prod <= key * HASH_MUL;
  end

  assign home = AW'(rem);
endmodule

>>> src/linear_probe_hash_map.sv
// Linear probe hash map: key/value table of SLOTS slots with open addressing. After reset a
// clearing pass writes zero to every slot of the key memory before the first beat is taken. Each
// operation hashes the key, then reads and checks one slot per probe, moving on to the next
// slot; a remove then re-places each entry of the following cluster (read it, hash its key,
// probe from its home slot) until the end of the cluster is found. One operation is in flight at
// a time; the result register frees the input.
// Depends on lphm_pkg, lphm_ram, lphm_hash.
module linear_probe_hash_map import lphm_pkg::*; #(
  parameter int SLOTS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [31:0] key,
  input  logic [31:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        found,
  output logic [31:0] value_out,
  output logic [1:0]  status
);
  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(SLOTS);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_HASH  = 4'd2;
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_CHK   = 4'd4;
  localparam logic [3:0] S_RES   = 4'd5;
  localparam logic [3:0] S_CRD   = 4'd6;
  localparam logic [3:0] S_CCHK  = 4'd7;
  localparam logic [3:0] S_PHASH = 4'd8;
  localparam logic [3:0] S_PRD   = 4'd9;
  localparam logic [3:0] S_PCHK  = 4'd10;

  logic [3:0]    state;
  logic [1:0]    op;
  logic [31:0]   op_key;
  logic [31:0]   op_val;
  logic [AW-1:0] pos;
  logic [CW-1:0] cnt;
  logic [AW-1:0] cpos;
  logic [CW-1:0] ccnt;
  logic [31:0]   mkey;
  logic [31:0]   mval;
  logic          res_found;
  logic [31:0]   res_val;
  logic [1:0]    res_status;

  logic          k_we;
  logic [AW-1:0] k_waddr;
  logic [31:0]   k_wdata;
  logic [AW-1:0] raddr;
  logic [31:0]   k_rdata;
  logic          v_we;
  logic [AW-1:0] v_waddr;
  logic [31:0]   v_wdata;
  logic [31:0]   v_rdata;
  logic [31:0]   hkey;
  logic [AW-1:0] home;
  logic [AW-1:0] pos_inc;
  logic [AW-1:0] cpos_inc;

  assign pos_inc = (pos == LAST) ? '0 : pos + 1'b1;
  assign cpos_inc = (cpos == LAST) ? '0 : cpos + 1'b1;
  assign hkey = (state == S_CCHK) ? k_rdata : key;

  lphm_hash #(.SLOTS(SLOTS)) u_hash (.clk(clk), .key(hkey), .home(home));

  lphm_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_keys (
    .clk(clk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
    .raddr(raddr), .rdata(k_rdata)
  );
  lphm_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_vals (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
    .raddr(raddr), .rdata(v_rdata)
  );

  assign in_stall = (state != S_IDLE);

  always_comb begin
    k_we = 1'b0;
    k_waddr = pos;
    k_wdata = '0;
    v_we = 1'b0;
    v_waddr = pos;
    v_wdata = op_val;
    raddr = pos;
    if (state == S_CLEAR) begin
      k_we = 1'b1;
    end else if (state == S_CHK) begin
      if (op == KIND_INSERT && k_rdata == op_key) begin
        v_we = 1'b1;
      end else if (op == KIND_INSERT && k_rdata == '0) begin
        k_we = 1'b1;
        k_wdata = op_key;
        v_we = 1'b1;
      end else if (op == KIND_REMOVE && k_rdata == op_key) begin
        k_we = 1'b1;
      end
    end else if (state == S_CCHK) begin
      if (k_rdata != '0 && ccnt != CNT_MAX) begin
        k_we = 1'b1;
        k_waddr = cpos;
      end
    end else if (state == S_PCHK) begin
      if (k_rdata == '0 || k_rdata == mkey) begin
        k_we = 1'b1;
        k_wdata = mkey;
        v_we = 1'b1;
        v_wdata = mval;
      end
    end
    if (state == S_CRD) begin
      raddr = cpos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      pos <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_RES) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          pos <= pos_inc;
          if (pos == LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op <= kind;
            op_key <= key;
            op_val <= value;
            if (key == '0) begin
              res_found <= 1'b0;
              res_val <= '0;
              res_status <= ST_ZERO;
              state <= S_RES;
            end else begin
              state <= S_HASH;
            end
          end
        end
        S_HASH: begin
          pos <= home;
          cnt <= '0;
          state <= S_RD;
        end
        S_RD: begin
          state <= S_CHK;
        end
        S_CHK: begin
          res_found <= 1'b0;
          res_val <= '0;
          res_status <= ST_DONE;
          if (k_rdata == op_key) begin
            res_found <= 1'b1;
            if (op != KIND_INSERT && op != KIND_REMOVE) begin
              res_val <= v_rdata;
            end
            if (op == KIND_REMOVE) begin
              cpos <= pos_inc;
              ccnt <= '0;
              state <= S_CRD;
            end else begin
              state <= S_RES;
            end
          end else if (k_rdata == '0) begin
            state <= S_RES;
          end else if (cnt + 1'b1 == CNT_MAX) begin
            if (op == KIND_INSERT) begin
              res_status <= ST_FULL;
            end
            state <= S_RES;
          end else begin
            cnt <= cnt + 1'b1;
            pos <= pos_inc;
            state <= S_RD;
          end
        end
        S_CRD: begin
          state <= S_CCHK;
        end
        S_CCHK: begin
          if (k_rdata == '0 || ccnt == CNT_MAX) begin
            state <= S_RES;
          end else begin
            mkey <= k_rdata;
            mval <= v_rdata;
            state <= S_PHASH;
          end
        end
        S_PHASH: begin
          pos <= home;
          cnt <= '0;
          state <= S_PRD;
        end
        S_PRD: begin
          state <= S_PCHK;
        end
        S_PCHK: begin
          if (k_rdata == '0 || k_rdata == mkey || cnt + 1'b1 == CNT_MAX) begin
            ccnt <= ccnt + 1'b1;
            cpos <= cpos_inc;
            state <= S_CRD;
          end else begin
            cnt <= cnt + 1'b1;
            pos <= pos_inc;
            state <= S_PRD;
          end
        end
        S_RES: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            found <= res_found;
            value_out <= res_val;
            status <= res_status;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

>>> src/lphm_checker.sv
// Port-level checker for the linear probe hash map, bound to the top level.
// Depends on assert_macros.svh, lphm_pkg and linear_probe_hash_map.
`include "assert_macros.svh"
module lphm_checker import lphm_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        found,
  input logic [31:0] value_out,
  input logic [1:0]  status
);
  `CHK_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(value_out))
  `CHK_IMPL(a_zero_key, clk, rst, out_valid && status == ST_ZERO, !found && value_out == '0)
  `CHK_IMPL(a_full_miss, clk, rst, out_valid && status == ST_FULL, !found)
  `CHK_NEXT(a_one_busy, clk, rst, in_valid && !in_stall, in_stall)
endmodule

bind linear_probe_hash_map lphm_checker u_lphm_checker (.*);
